// ----- rtl/b64enc_pkg.sv -----
// Package for the base64 stream encoder.
// Holds the group phase codes, the character job carried between the front
// and back parts, and the sextet-to-ASCII mapping. No dependencies.
package b64enc_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned JobSlots = 4;
  localparam logic [CharW-1:0] PadChar = 8'h3D;  // '='

  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2
  } phase_e;

  // Characters produced by one input byte; last_idx is the slot of the
  // final valid character, fin marks the end of the encoded message.
  typedef struct packed {
    logic [JobSlots-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;
    logic                           fin;
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- rtl/b64enc_front.sv -----
// Front part of the base64 stream encoder: accepts bytes, tracks the group
// phase and leftover bits, and builds one character job per byte.
// Depends on b64enc_pkg.
module b64enc_front import b64enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output job_t       q_job_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  always_comb begin
    q_job_o          = '0;
    q_job_o.chars    = {JobSlots{PadChar}};
    q_job_o.fin      = final_byte_i;
    q_job_o.last_idx = 2'd0;
    phase_d          = phase_q;
    left_d           = left_q;
    unique case (phase_q)
      PhaseSecond: begin
        q_job_o.chars[0] = sextet_char({left_q[1:0], data_byte_i[7:4]});
        if (final_byte_i) begin
          q_job_o.chars[1] = sextet_char({data_byte_i[3:0], 2'b00});
          q_job_o.last_idx = 2'd2;
        end
        left_d  = data_byte_i[3:0];
        phase_d = PhaseThird;
      end
      PhaseThird: begin
        q_job_o.chars[0] = sextet_char({left_q, data_byte_i[7:6]});
        q_job_o.chars[1] = sextet_char(data_byte_i[5:0]);
        q_job_o.last_idx = 2'd1;
        left_d  = '0;
        phase_d = PhaseFirst;
      end
      default: begin
        q_job_o.chars[0] = sextet_char(data_byte_i[7:2]);
        if (final_byte_i) begin
          q_job_o.chars[1] = sextet_char({data_byte_i[1:0], 4'b0000});
          q_job_o.last_idx = 2'd3;
        end
        left_d  = {2'b00, data_byte_i[1:0]};
        phase_d = PhaseSecond;
      end
    endcase
    // Message end: return to a fresh group.
    if (final_byte_i) begin
      phase_d = PhaseFirst;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// ----- rtl/b64enc_queue.sv -----
// Short job queue between the front and back parts of the base64 encoder.
// Register-based FIFO of character jobs. Depends on b64enc_pkg.
module b64enc_queue import b64enc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> valid_o) else $error("queue empty after push");
`endif

endmodule

// ----- rtl/b64enc_back.sv -----
// Back part of the base64 encoder: pops character jobs and emits one
// character per beat through a registered output. Depends on b64enc_pkg.
module b64enc_back import b64enc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  job_t             q_job_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             last_char_o
);

  logic [1:0]       idx_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load;
  logic             at_end;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign at_end  = (idx_q == q_job_i.last_idx);
  assign q_pop_o = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= at_end ? 2'd0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= q_job_i.chars[idx_q];
      last_q <= at_end && q_job_i.fin;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// Streaming base64 encoder, standard alphabet with '=' padding.
// A byte's job goes into the job queue, and from there into the output register.
// Throughput: one character per cycle at the output register while out_ready_i holds
// and a job is queued; a byte is taken every cycle while the job queue has room.
// Reset (async, active low) empties the queue, drops the output beat and
// returns the group phase to the start of a group.
module base64_stream_encoder import b64enc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  logic q_push, q_full, q_pop, q_valid;
  job_t push_job, head_job;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (push_job)
  );

  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule
